// ===== hw/rtl/cia_pkg.sv =====
package cia_pkg;

	// Operand and counter widths
	localparam int DATA_W = 64;
	localparam int HALF_W = DATA_W / 2;
	localparam int CNT_W = $clog2(DATA_W);
	localparam int MAX_EXPONENT_DEF = 20;

	// Result status codes
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_DEFER = 2'd1,
		ST_ERR   = 2'd2
	} st_t;

	// Error kinds
	typedef enum logic [2:0] {
		EK_NONE = 3'd0,
		EK_OVF  = 3'd1,
		EK_DIV0 = 3'd2,
		EK_BAD  = 3'd3,
		EK_NEG  = 3'd4,
		EK_BIG  = 3'd5
	} ek_t;

	// Where the decoded operation goes after the classify state
	typedef enum logic [1:0] {
		RT_FAST = 2'd0,
		RT_MUL  = 2'd1,
		RT_POW  = 2'd2,
		RT_DIV  = 2'd3
	} route_t;

	// Source of the value written into the result register
	typedef enum logic [1:0] {
		SRC_FAST = 2'd0,
		SRC_MUL  = 2'd1,
		SRC_DIV  = 2'd2
	} res_src_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic     take;
		logic     res_load;
		res_src_t res_src;
		logic     mload;
		logic     pp_en;
		logic [1:0] pp_sel;
		logic     acc_en;
		logic [1:0] acc_sel;
		logic     pow_next;
		logic     dload;
		logic     dstep;
	} cia_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		route_t route;
		logic   mul_ovf;
		logic   pow_last;
	} cia_stat_t;

endpackage

// ===== hw/rtl/cia_ctrl.sv =====
module cia_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  cia_pkg::cia_stat_t   stat,
	output cia_pkg::cia_cmd_t    ctl,
	output logic                 busy,
	output logic                 done
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_CLASS,
		S_MLOAD,
		S_MSTEP,
		S_MCHK,
		S_DLOAD,
		S_DSTEP,
		S_DFIX
	} state_t;

	localparam logic [cia_pkg::CNT_W-1:0] MUL_LAST = cia_pkg::CNT_W'(4);
	localparam logic [cia_pkg::CNT_W-1:0] DIV_LAST = cia_pkg::CNT_W'(cia_pkg::DATA_W - 1);

	state_t                    state_q;
	logic [cia_pkg::CNT_W-1:0] step_q;
	logic [cia_pkg::CNT_W-1:0] step_m1;
	logic                      busy_q;
	logic                      done_q;
	logic                      take;

	assign take    = start & ~busy_q;
	assign step_m1 = step_q - 1'b1;
	assign busy    = busy_q;
	assign done    = done_q;

	// Command decode from the current state
	always_comb begin
		ctl          = '0;
		ctl.res_src  = cia_pkg::SRC_FAST;
		ctl.take     = take;
		case (state_q)
			S_CLASS: begin
				if (stat.route == cia_pkg::RT_FAST) begin
					ctl.res_load = 1'b1;
					ctl.res_src  = cia_pkg::SRC_FAST;
				end
			end
			S_MLOAD: begin
				ctl.mload = 1'b1;
			end
			S_MSTEP: begin
				// partial product k is formed in step k, added in step k+1
				ctl.pp_en   = (step_q != MUL_LAST);
				ctl.pp_sel  = step_q[1:0];
				ctl.acc_en  = (step_q != '0);
				ctl.acc_sel = step_m1[1:0];
			end
			S_MCHK: begin
				if (stat.route == cia_pkg::RT_MUL || stat.mul_ovf || stat.pow_last) begin
					ctl.res_load = 1'b1;
					ctl.res_src  = cia_pkg::SRC_MUL;
				end else begin
					ctl.pow_next = 1'b1;
				end
			end
			S_DLOAD: begin
				ctl.dload = 1'b1;
			end
			S_DSTEP: begin
				ctl.dstep = 1'b1;
			end
			S_DFIX: begin
				ctl.res_load = 1'b1;
				ctl.res_src  = cia_pkg::SRC_DIV;
			end
			default: begin
			end
		endcase
	end

	// State, step counter and registered handshake outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= '0;
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (take) begin
						state_q <= S_CLASS;
						busy_q  <= 1'b1;
					end
				end
				S_CLASS: begin
					case (stat.route)
						cia_pkg::RT_MUL, cia_pkg::RT_POW: state_q <= S_MLOAD;
						cia_pkg::RT_DIV:                  state_q <= S_DLOAD;
						default:                          state_q <= S_IDLE;
					endcase
				end
				S_MLOAD: begin
					step_q  <= '0;
					state_q <= S_MSTEP;
				end
				S_MSTEP: begin
					if (step_q == MUL_LAST) begin
						state_q <= S_MCHK;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				S_MCHK: begin
					if (ctl.res_load) begin
						state_q <= S_IDLE;
					end else begin
						state_q <= S_MLOAD;
					end
				end
				S_DLOAD: begin
					step_q  <= '0;
					state_q <= S_DSTEP;
				end
				S_DSTEP: begin
					if (step_q == DIV_LAST) begin
						state_q <= S_DFIX;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				S_DFIX: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (ctl.res_load) begin
				done_q <= 1'b1;
				busy_q <= 1'b0;
			end
		end
	end

	// A finished beat never overlaps a busy cycle
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q)
		else $error("done asserted while busy");

	// An accepted beat makes the block busy with no stale strobe
	a_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> (busy_q && !done_q))
		else $error("accepted beat did not raise busy");

	// Busy tracks the sequencer
	a_busy_state: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q == (state_q != S_IDLE))
		else $error("busy out of step with state");

endmodule

// ===== hw/rtl/cia_dpath.sv =====
module cia_dpath #(
	parameter int MAX_EXPONENT = cia_pkg::MAX_EXPONENT_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  cia_pkg::cia_cmd_t                  ctl,
	output cia_pkg::cia_stat_t                 stat,
	input  logic [4:0]                         op,
	input  logic signed [cia_pkg::DATA_W-1:0]  left_value,
	input  logic signed [cia_pkg::DATA_W-1:0]  right_value,
	input  logic [1:0]                         left_kind,
	input  logic [1:0]                         right_kind,
	output logic [1:0]                         status,
	output logic [2:0]                         error_kind,
	output logic signed [cia_pkg::DATA_W-1:0]  result_value
);

	localparam int DW = cia_pkg::DATA_W;
	localparam int HW = cia_pkg::HALF_W;
	localparam int EXP_W = $clog2(MAX_EXPONENT + 1);
	localparam logic [DW-1:0] EXP_MAX = DW'(MAX_EXPONENT);
	localparam logic [DW-1:0] SIGN_BIT = {1'b1, {(DW-1){1'b0}}};
	localparam logic [DW-1:0] MINUS_ONE = '1;
	localparam logic [DW-1:0] ONE = DW'(1);
	localparam logic [DW-1:0] SHIFT_LIMIT = DW'(DW);
	localparam logic [1:0] KIND_INT = 2'd0;
	localparam logic [1:0] KIND_BOOL = 2'd1;

	typedef enum logic [4:0] {
		OP_ADD  = 5'd0,
		OP_SUB  = 5'd1,
		OP_MUL  = 5'd2,
		OP_DIV  = 5'd3,
		OP_MOD  = 5'd4,
		OP_POW  = 5'd5,
		OP_EQ   = 5'd6,
		OP_NE   = 5'd7,
		OP_LT   = 5'd8,
		OP_GT   = 5'd9,
		OP_LE   = 5'd10,
		OP_GE   = 5'd11,
		OP_AND  = 5'd12,
		OP_OR   = 5'd13,
		OP_BAND = 5'd14,
		OP_BOR  = 5'd15,
		OP_BXOR = 5'd16,
		OP_SHL  = 5'd17,
		OP_SHR  = 5'd18
	} op_t;

	typedef struct packed {
		cia_pkg::st_t  st;
		cia_pkg::ek_t  ek;
		logic [DW-1:0] val;
	} res_t;

	// Error kind only on errors, value only on success
	function automatic res_t mk(cia_pkg::st_t st, cia_pkg::ek_t ek, logic [DW-1:0] val);
		res_t r;
		r.st  = st;
		r.ek  = (st == cia_pkg::ST_ERR) ? ek : cia_pkg::EK_NONE;
		r.val = (st == cia_pkg::ST_OK) ? val : '0;
		return r;
	endfunction

	function automatic logic [DW-1:0] mag(logic [DW-1:0] v);
		return v[DW-1] ? (~v + 1'b1) : v;
	endfunction

	// Operand registers
	op_t                  op_q;
	logic signed [DW-1:0] a_q;
	logic signed [DW-1:0] b_q;
	logic [1:0]           lk_q;
	logic [1:0]           rk_q;

	// Multiply and power registers
	logic [DW-1:0]   acc_q;
	logic [EXP_W-1:0] exp_q;
	logic [DW-1:0]   mx_q;
	logic [DW-1:0]   my_q;
	logic            mneg_q;
	logic [DW-1:0]   pp_q;
	logic [2*DW-1:0] prod_q;

	// Divider registers
	logic [DW-1:0] dq_q;
	logic [DW-1:0] dv_q;
	logic [DW-1:0] rem_q;

	// Result register
	res_t res_q;

	// Fast path signals
	logic          ints;
	logic          bools;
	logic [DW-1:0] sum;
	logic [DW-1:0] diff;
	logic          lt_ab;
	logic          lt_ba;
	res_t          fast;
	cia_pkg::route_t route;

	// Multiply signals
	logic [HW-1:0]   px;
	logic [HW-1:0]   py;
	logic [2*DW-1:0] pp_shifted;
	logic [DW-1:0]   mlo;
	logic            mul_ovf;
	logic [DW-1:0]   mval;

	// Divider signals
	logic [DW-1:0] dshift;
	logic [DW:0]   dtrial;
	logic [DW-1:0] dval;
	res_t          res_d;

	assign ints  = (lk_q == KIND_INT) && (rk_q == KIND_INT);
	assign bools = (lk_q == KIND_BOOL) && (rk_q == KIND_BOOL);
	assign sum   = a_q + b_q;
	assign diff  = a_q - b_q;
	assign lt_ab = a_q < b_q;
	assign lt_ba = b_q < a_q;

	// Fast-path operations and routing of the long ones
	always_comb begin
		fast  = mk(cia_pkg::ST_DEFER, cia_pkg::EK_NONE, '0);
		route = cia_pkg::RT_FAST;
		case (op_q)
			OP_ADD: begin
				if (!ints) begin
					fast = mk(cia_pkg::ST_DEFER, cia_pkg::EK_NONE, '0);
				end else if (a_q[DW-1] == b_q[DW-1] && sum[DW-1] != a_q[DW-1]) begin
					fast = mk(cia_pkg::ST_ERR, cia_pkg::EK_OVF, '0);
				end else begin
					fast = mk(cia_pkg::ST_OK, cia_pkg::EK_NONE, sum);
				end
			end
			OP_SUB: begin
				if (!ints) begin
					fast = mk(cia_pkg::ST_DEFER, cia_pkg::EK_NONE, '0);
				end else if (a_q[DW-1] != b_q[DW-1] && diff[DW-1] != a_q[DW-1]) begin
					fast = mk(cia_pkg::ST_ERR, cia_pkg::EK_OVF, '0);
				end else begin
					fast = mk(cia_pkg::ST_OK, cia_pkg::EK_NONE, diff);
				end
			end
			OP_MUL: begin
				if (ints) begin
					route = cia_pkg::RT_MUL;
				end
			end
			OP_DIV, OP_MOD: begin
				if (!ints) begin
					fast = (op_q == OP_DIV) ? mk(cia_pkg::ST_DEFER, cia_pkg::EK_NONE, '0)
					                        : mk(cia_pkg::ST_ERR, cia_pkg::EK_BAD, '0);
				end else if (b_q == '0) begin
					fast = mk(cia_pkg::ST_ERR, cia_pkg::EK_DIV0, '0);
				end else if (a_q == SIGN_BIT && b_q == MINUS_ONE) begin
					fast = mk(cia_pkg::ST_ERR, cia_pkg::EK_OVF, '0);
				end else begin
					route = cia_pkg::RT_DIV;
				end
			end
			OP_POW: begin
				if (!ints) begin
					fast = mk(cia_pkg::ST_DEFER, cia_pkg::EK_NONE, '0);
				end else if (b_q[DW-1]) begin
					fast = mk(cia_pkg::ST_ERR, cia_pkg::EK_NEG, '0);
				end else if (b_q > EXP_MAX) begin
					fast = mk(cia_pkg::ST_ERR, cia_pkg::EK_BIG, '0);
				end else if (b_q == '0) begin
					fast = mk(cia_pkg::ST_OK, cia_pkg::EK_NONE, ONE);
				end else begin
					route = cia_pkg::RT_POW;
				end
			end
			OP_EQ, OP_NE, OP_LT, OP_GT, OP_LE, OP_GE: begin
				if (ints) begin
					case (op_q)
						OP_EQ:   fast = mk(cia_pkg::ST_OK, cia_pkg::EK_NONE, DW'(a_q == b_q));
						OP_NE:   fast = mk(cia_pkg::ST_OK, cia_pkg::EK_NONE, DW'(a_q != b_q));
						OP_LT:   fast = mk(cia_pkg::ST_OK, cia_pkg::EK_NONE, DW'(lt_ab));
						OP_GT:   fast = mk(cia_pkg::ST_OK, cia_pkg::EK_NONE, DW'(lt_ba));
						OP_LE:   fast = mk(cia_pkg::ST_OK, cia_pkg::EK_NONE, DW'(!lt_ba));
						default: fast = mk(cia_pkg::ST_OK, cia_pkg::EK_NONE, DW'(!lt_ab));
					endcase
				end
			end
			OP_AND, OP_OR: begin
				if (!bools) begin
					fast = mk(cia_pkg::ST_ERR, cia_pkg::EK_BAD, '0);
				end else if (op_q == OP_AND) begin
					fast = mk(cia_pkg::ST_OK, cia_pkg::EK_NONE, DW'(a_q != '0 && b_q != '0));
				end else begin
					fast = mk(cia_pkg::ST_OK, cia_pkg::EK_NONE, DW'(a_q != '0 || b_q != '0));
				end
			end
			OP_BAND, OP_BOR, OP_BXOR: begin
				if (!ints) begin
					fast = mk(cia_pkg::ST_ERR, cia_pkg::EK_BAD, '0);
				end else if (op_q == OP_BAND) begin
					fast = mk(cia_pkg::ST_OK, cia_pkg::EK_NONE, a_q & b_q);
				end else if (op_q == OP_BOR) begin
					fast = mk(cia_pkg::ST_OK, cia_pkg::EK_NONE, a_q | b_q);
				end else begin
					fast = mk(cia_pkg::ST_OK, cia_pkg::EK_NONE, a_q ^ b_q);
				end
			end
			OP_SHL, OP_SHR: begin
				if (!ints) begin
					fast = mk(cia_pkg::ST_ERR, cia_pkg::EK_BAD, '0);
				end else if (b_q[DW-1]) begin
					fast = mk(cia_pkg::ST_ERR, cia_pkg::EK_NEG, '0);
				end else if (b_q >= SHIFT_LIMIT) begin
					fast = mk(cia_pkg::ST_ERR, cia_pkg::EK_BIG, '0);
				end else if (op_q == OP_SHL) begin
					fast = mk(cia_pkg::ST_OK, cia_pkg::EK_NONE,
						a_q << b_q[cia_pkg::CNT_W-1:0]);
				end else begin
					fast = mk(cia_pkg::ST_OK, cia_pkg::EK_NONE,
						a_q >>> b_q[cia_pkg::CNT_W-1:0]);
				end
			end
			default: begin
				fast = mk(cia_pkg::ST_DEFER, cia_pkg::EK_NONE, '0);
			end
		endcase
	end

	// Partial product operand halves
	always_comb begin
		case (ctl.pp_sel)
			2'd0: begin px = mx_q[HW-1:0];  py = my_q[HW-1:0];  end
			2'd1: begin px = mx_q[HW-1:0];  py = my_q[DW-1:HW]; end
			2'd2: begin px = mx_q[DW-1:HW]; py = my_q[HW-1:0];  end
			default: begin px = mx_q[DW-1:HW]; py = my_q[DW-1:HW]; end
		endcase
	end

	// Alignment of the registered partial product
	always_comb begin
		case (ctl.acc_sel)
			2'd0:    pp_shifted = {{DW{1'b0}}, pp_q};
			2'd1,
			2'd2:    pp_shifted = {{HW{1'b0}}, pp_q, {HW{1'b0}}};
			default: pp_shifted = {pp_q, {DW{1'b0}}};
		endcase
	end

	// Overflow check and sign of the 128-bit magnitude product
	assign mlo     = prod_q[DW-1:0];
	assign mul_ovf = (prod_q[2*DW-1:DW] != '0) || (mneg_q ? (mlo > SIGN_BIT) : mlo[DW-1]);
	assign mval    = mneg_q ? (~mlo + 1'b1) : mlo;

	// Restoring divider step
	assign dshift = {rem_q[DW-2:0], dq_q[DW-1]};
	assign dtrial = {1'b0, dshift} - {1'b0, dv_q};
	always_comb begin
		if (op_q == OP_DIV) begin
			dval = (a_q[DW-1] ^ b_q[DW-1]) ? (~dq_q + 1'b1) : dq_q;
		end else begin
			dval = a_q[DW-1] ? (~rem_q + 1'b1) : rem_q;
		end
	end

	// Next result
	always_comb begin
		case (ctl.res_src)
			cia_pkg::SRC_MUL: begin
				res_d = mul_ovf ? mk(cia_pkg::ST_ERR, cia_pkg::EK_OVF, '0)
				                : mk(cia_pkg::ST_OK, cia_pkg::EK_NONE, mval);
			end
			cia_pkg::SRC_DIV: res_d = mk(cia_pkg::ST_OK, cia_pkg::EK_NONE, dval);
			default:          res_d = fast;
		endcase
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (ctl.take) begin
			op_q  <= op_t'(op);
			a_q   <= left_value;
			b_q   <= right_value;
			lk_q  <= left_kind;
			rk_q  <= right_kind;
			acc_q <= ONE;
			exp_q <= right_value[EXP_W-1:0];
		end
		if (ctl.pow_next) begin
			acc_q <= mval;
			exp_q <= exp_q - 1'b1;
		end
		if (ctl.mload) begin
			mx_q   <= (op_q == OP_POW) ? mag(acc_q) : mag(a_q);
			my_q   <= (op_q == OP_POW) ? mag(a_q) : mag(b_q);
			mneg_q <= (op_q == OP_POW) ? (acc_q[DW-1] ^ a_q[DW-1]) : (a_q[DW-1] ^ b_q[DW-1]);
			prod_q <= '0;
		end else if (ctl.acc_en) begin
			prod_q <= prod_q + pp_shifted;
		end
		if (ctl.pp_en) begin
			pp_q <= px * py;
		end
		if (ctl.dload) begin
			dq_q  <= mag(a_q);
			dv_q  <= mag(b_q);
			rem_q <= '0;
		end else if (ctl.dstep) begin
			if (!dtrial[DW]) begin
				rem_q <= dtrial[DW-1:0];
			end else begin
				rem_q <= dshift;
			end
			dq_q <= {dq_q[DW-2:0], !dtrial[DW]};
		end
		if (ctl.res_load) begin
			res_q <= res_d;
		end
	end

	assign stat.route    = route;
	assign stat.mul_ovf  = mul_ovf;
	assign stat.pow_last = (exp_q == EXP_W'(1));

	assign status       = res_q.st;
	assign error_kind   = res_q.ek;
	assign result_value = res_q.val;

	// The power loop never steps past its last multiply
	a_pow_count: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.pow_next |-> (exp_q > EXP_W'(1)))
		else $error("power step with exponent count exhausted");

	// A loaded result carries a value only on success
	a_res_zero: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.res_load |=> ((res_q.st == cia_pkg::ST_OK) || (res_q.val == '0)))
		else $error("nonzero value on a failed result");

endmodule

// ===== hw/rtl/checked_int64_alu.sv =====
// Checked 64-bit integer ALU. An item is taken when start is high and busy is low;
// its result appears on status, error_kind and result_value for the single cycle
// in which done is high, and the receiver cannot hold it off, so it must capture
// the beat then. Busy drops in that same cycle, so the next item can be taken
// while a result is shown. Add, sub, compares, logic, bitwise ops, shifts and
// every deferred item or item rejected on its operands take the fast path; mul
// runs four 32x32 partial products through one shared multiplier; div and mod
// use the one-bit-per-cycle restoring divider; pow repeats the checked multiply
// once per exponent step (up to MAX_EXPONENT).
module checked_int64_alu #(
	parameter int MAX_EXPONENT = cia_pkg::MAX_EXPONENT_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [4:0]                         cmd,
	input  logic signed [cia_pkg::DATA_W-1:0]  left_value,
	input  logic signed [cia_pkg::DATA_W-1:0]  right_value,
	input  logic [1:0]                         left_kind,
	input  logic [1:0]                         right_kind,
	output logic                               done,
	output logic [1:0]                         status,
	output logic [2:0]                         error_kind,
	output logic signed [cia_pkg::DATA_W-1:0]  result_value
);

	cia_pkg::cia_cmd_t  ctl;
	cia_pkg::cia_stat_t stat;

	// Sequencer
	cia_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.ctl    (ctl),
		.busy   (busy),
		.done   (done)
	);

	// Operand, arithmetic and result registers
	cia_dpath #(
		.MAX_EXPONENT (MAX_EXPONENT)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.stat         (stat),
		.op           (cmd),
		.left_value   (left_value),
		.right_value  (right_value),
		.left_kind    (left_kind),
		.right_kind   (right_kind),
		.status       (status),
		.error_kind   (error_kind),
		.result_value (result_value)
	);

endmodule

// ===== tb/checked_int64_alu_tb.sv =====
`timescale 1ns / 1ps

module checked_int64_alu_tb;

	localparam int DATA_W = cia_pkg::DATA_W;
	localparam int WIDE_W = 2 * DATA_W;
	localparam int CNT_W = cia_pkg::CNT_W;

	// Opcodes as the block decodes them
	typedef enum logic [4:0] {
		OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_POW,
		OP_EQ, OP_NE, OP_LT, OP_GT, OP_LE, OP_GE,
		OP_LAND, OP_LOR, OP_BAND, OP_BOR, OP_BXOR, OP_SHL, OP_SHR
	} alu_op_t;

	localparam int OP_CODE_TOP = 31;    // top of the 5-bit opcode space

	// Operand kinds
	localparam logic [1:0] KIND_INT   = 2'd0;
	localparam logic [1:0] KIND_BOOL  = 2'd1;
	localparam logic [1:0] KIND_OTHER = 2'd2;
	localparam logic [1:0] KIND_SPARE = 2'd3;

	localparam int POW_LIMIT = cia_pkg::MAX_EXPONENT_DEF;
	localparam int SETTLE_CYCLES = 200;   // longer than the slowest pow
	localparam int RANDOM_BEATS = 600;

	localparam logic signed [DATA_W-1:0] I64_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic signed [DATA_W-1:0] I64_MIN = {1'b1, {(DATA_W-1){1'b0}}};
	localparam logic signed [DATA_W-1:0] MINUS_ONE = '1;

	typedef struct {
		logic [4:0]               op;
		logic signed [DATA_W-1:0] lhs;
		logic signed [DATA_W-1:0] rhs;
		logic [1:0]               lkind;
		logic [1:0]               rkind;
		int                       gap;     // idle cycles after this beat
		bit                       drain;   // wait for the block to empty first
	} alu_beat_t;

	typedef struct {
		logic [4:0]               op;
		logic signed [DATA_W-1:0] lhs;
		logic signed [DATA_W-1:0] rhs;
		cia_pkg::st_t             status;
		cia_pkg::ek_t             err;
		logic signed [DATA_W-1:0] value;
	} alu_outcome_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [4:0] cmd = '0;
	logic signed [DATA_W-1:0] left_value = '0;
	logic signed [DATA_W-1:0] right_value = '0;
	logic [1:0] left_kind = '0;
	logic [1:0] right_kind = '0;
	logic busy;
	logic done;
	logic [1:0] status;
	logic [2:0] error_kind;
	logic signed [DATA_W-1:0] result_value;

	alu_beat_t    alu_pending[$];
	alu_outcome_t alu_expected[$];

	int gap_left = 0;
	int n_acc = 0;
	int n_res = 0;
	int n_err = 0;
	int n_total = 0;
	int n_directed = 0;
	int n_valid = 0;
	int n_defer = 0;
	int n_fault = 0;

	checked_int64_alu dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.left_value(left_value),
		.right_value(right_value),
		.left_kind(left_kind),
		.right_kind(right_kind),
		.done(done),
		.status(status),
		.error_kind(error_kind),
		.result_value(result_value)
	);

	always #4 clk = ~clk;

	task automatic report_mismatch(string msg);
		$display("MISMATCH at %0t ns: %s", $time, msg);
		n_err++;
	endtask

	// Exact signed product; returns 1 when it fits in 64 bits
	function automatic bit mul_in_range(input logic signed [DATA_W-1:0] x,
			input logic signed [DATA_W-1:0] y, output logic signed [DATA_W-1:0] p);
		logic signed [WIDE_W-1:0] full;
		full = WIDE_W'(x) * WIDE_W'(y);
		p = full[DATA_W-1:0];
		return full[WIDE_W-1:DATA_W-1] == {(DATA_W+1){full[DATA_W-1]}};
	endfunction

	// Expected outcome of one ALU operation
	function automatic alu_outcome_t predict_alu(logic [4:0] op, logic signed [DATA_W-1:0] a,
			logic signed [DATA_W-1:0] b, logic [1:0] lk, logic [1:0] rk);
		alu_outcome_t r;
		logic ints;
		logic bools;
		logic signed [DATA_W:0] wide;
		logic signed [DATA_W-1:0] acc;
		logic signed [DATA_W-1:0] step;
		r.op = op;
		r.lhs = a;
		r.rhs = b;
		r.status = cia_pkg::ST_OK;
		r.err = cia_pkg::EK_NONE;
		r.value = '0;
		ints = (lk == KIND_INT) && (rk == KIND_INT);
		bools = (lk == KIND_BOOL) && (rk == KIND_BOOL);
		case (op)
			OP_ADD, OP_SUB: begin
				if (!ints) begin
					r.status = cia_pkg::ST_DEFER;
				end else begin
					wide = (op == OP_ADD) ? {a[DATA_W-1], a} + {b[DATA_W-1], b}
					                      : {a[DATA_W-1], a} - {b[DATA_W-1], b};
					if (wide[DATA_W] != wide[DATA_W-1]) begin
						r.status = cia_pkg::ST_ERR;
						r.err = cia_pkg::EK_OVF;
					end else begin
						r.value = wide[DATA_W-1:0];
					end
				end
			end
			OP_MUL: begin
				if (!ints) begin
					r.status = cia_pkg::ST_DEFER;
				end else if (!mul_in_range(a, b, acc)) begin
					r.status = cia_pkg::ST_ERR;
					r.err = cia_pkg::EK_OVF;
				end else begin
					r.value = acc;
				end
			end
			OP_DIV, OP_MOD: begin
				if (!ints) begin
					r.status = (op == OP_DIV) ? cia_pkg::ST_DEFER : cia_pkg::ST_ERR;
					r.err = cia_pkg::EK_BAD;
				end else if (b == 0) begin
					r.status = cia_pkg::ST_ERR;
					r.err = cia_pkg::EK_DIV0;
				end else if (a == I64_MIN && b == MINUS_ONE) begin
					r.status = cia_pkg::ST_ERR;
					r.err = cia_pkg::EK_OVF;
				end else begin
					// signed operands: truncating divide, remainder follows dividend
					r.value = (op == OP_DIV) ? a / b : a % b;
				end
			end
			OP_POW: begin
				if (!ints) begin
					r.status = cia_pkg::ST_DEFER;
				end else if (b < 0) begin
					r.status = cia_pkg::ST_ERR;
					r.err = cia_pkg::EK_NEG;
				end else if (b > POW_LIMIT) begin
					r.status = cia_pkg::ST_ERR;
					r.err = cia_pkg::EK_BIG;
				end else begin
					acc = 1;
					for (int i = 0; i < b; i++) begin
						if (r.status == cia_pkg::ST_OK) begin
							if (!mul_in_range(acc, a, step)) begin
								r.status = cia_pkg::ST_ERR;
								r.err = cia_pkg::EK_OVF;
							end
							acc = step;
						end
					end
					r.value = acc;
				end
			end
			OP_EQ, OP_NE, OP_LT, OP_GT, OP_LE, OP_GE: begin
				if (!ints) begin
					r.status = cia_pkg::ST_DEFER;
				end else begin
					case (op)
						OP_EQ: r.value = DATA_W'(a == b);
						OP_NE: r.value = DATA_W'(a != b);
						OP_LT: r.value = DATA_W'(a < b);
						OP_GT: r.value = DATA_W'(a > b);
						OP_LE: r.value = DATA_W'(a <= b);
						default: r.value = DATA_W'(a >= b);
					endcase
				end
			end
			OP_LAND, OP_LOR: begin
				if (!bools) begin
					r.status = cia_pkg::ST_ERR;
					r.err = cia_pkg::EK_BAD;
				end else if (op == OP_LAND) begin
					r.value = DATA_W'((a != 0) && (b != 0));
				end else begin
					r.value = DATA_W'((a != 0) || (b != 0));
				end
			end
			OP_BAND, OP_BOR, OP_BXOR: begin
				if (!ints) begin
					r.status = cia_pkg::ST_ERR;
					r.err = cia_pkg::EK_BAD;
				end else begin
					r.value = (op == OP_BAND) ? a & b : (op == OP_BOR) ? a | b : a ^ b;
				end
			end
			OP_SHL, OP_SHR: begin
				if (!ints) begin
					r.status = cia_pkg::ST_ERR;
					r.err = cia_pkg::EK_BAD;
				end else if (b < 0) begin
					r.status = cia_pkg::ST_ERR;
					r.err = cia_pkg::EK_NEG;
				end else if (b >= DATA_W) begin
					r.status = cia_pkg::ST_ERR;
					r.err = cia_pkg::EK_BIG;
				end else begin
					r.value = (op == OP_SHL) ? a << b[CNT_W-1:0] : a >>> b[CNT_W-1:0];
				end
			end
			default: r.status = cia_pkg::ST_DEFER;
		endcase
		// error kind only with an error, value only when valid
		if (r.status != cia_pkg::ST_ERR)
			r.err = cia_pkg::EK_NONE;
		if (r.status != cia_pkg::ST_OK)
			r.value = '0;
		return r;
	endfunction

	// Idle length after a beat: mostly none or short, a few long
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(99, 0);
		if (roll < 55)
			return 0;
		if (roll < 90)
			return $urandom_range(3, 1);
		return $urandom_range(40, 8);
	endfunction

	// Operand spread across full, small, half-width, corner and power-of-two values
	function automatic logic signed [DATA_W-1:0] pick_operand();
		logic signed [DATA_W-1:0] v;
		case ($urandom_range(9, 0))
			0, 1, 2: v = {$urandom, $urandom};
			3, 4, 5: v = $signed(64'($urandom_range(200, 0))) - 100;
			6, 7: v = DATA_W'($signed($urandom));
			8: begin
				case ($urandom_range(6, 0))
					0: v = I64_MIN;
					1: v = I64_MAX;
					2: v = 0;
					3: v = 1;
					4: v = MINUS_ONE;
					5: v = I64_MIN + 1;
					default: v = I64_MAX - 1;
				endcase
			end
			default: begin
				v = 64'sd1 <<< $urandom_range(DATA_W - 1, 0);
				if ($urandom_range(1, 0))
					v = -v;
			end
		endcase
		return v;
	endfunction

	task automatic add_beat(logic [4:0] op, logic signed [DATA_W-1:0] a,
			logic signed [DATA_W-1:0] b, logic [1:0] lk, logic [1:0] rk, bit drain);
		alu_beat_t it;
		it.op = op;
		it.lhs = a;
		it.rhs = b;
		it.lkind = lk;
		it.rkind = rk;
		it.gap = pick_gap();
		it.drain = drain;
		alu_pending.push_back(it);
		n_total++;
	endtask

	// Driver: one beat at a time, held until busy is low
	always @(posedge clk or negedge arst_n) begin
		alu_beat_t it;
		if (!arst_n) begin
			start <= 1'b0;
			cmd <= '0;
			left_value <= '0;
			right_value <= '0;
			left_kind <= KIND_INT;
			right_kind <= KIND_INT;
			gap_left <= 0;
		end else if (!(start && !busy) && start) begin
			// offered but not taken yet: hold
		end else if (gap_left != 0) begin
			start <= 1'b0;
			gap_left <= gap_left - 1;
		end else if (alu_pending.size() != 0 &&
				!(alu_pending[0].drain && (start || n_acc != n_res))) begin
			it = alu_pending.pop_front();
			cmd <= it.op;
			left_value <= it.lhs;
			right_value <= it.rhs;
			left_kind <= it.lkind;
			right_kind <= it.rkind;
			gap_left <= it.gap;
			start <= 1'b1;
		end else begin
			start <= 1'b0;
		end
	end

	// Monitor: check the result beat, then log the beat accepted at this edge
	always @(posedge clk) begin
		alu_outcome_t want;
		if (arst_n) begin
			if (done) begin
				n_res <= n_res + 1;
				if (alu_expected.size() == 0) begin
					report_mismatch("result beat with nothing outstanding");
				end else begin
					want = alu_expected.pop_front();
					if (status !== want.status)
						report_mismatch($sformatf("op %0d a=%0d b=%0d: status %0d, want %0d",
							want.op, want.lhs, want.rhs, status, want.status));
					if (error_kind !== want.err)
						report_mismatch($sformatf("op %0d a=%0d b=%0d: error %0d, want %0d",
							want.op, want.lhs, want.rhs, error_kind, want.err));
					if (result_value !== want.value)
						report_mismatch($sformatf("op %0d a=%0d b=%0d: value %0d, want %0d",
							want.op, want.lhs, want.rhs, result_value, want.value));
				end
			end
			if (start && !busy) begin
				want = predict_alu(cmd, left_value, right_value, left_kind, right_kind);
				alu_expected.push_back(want);
				n_acc <= n_acc + 1;
				case (want.status)
					cia_pkg::ST_OK: n_valid++;
					cia_pkg::ST_DEFER: n_defer++;
					default: n_fault++;
				endcase
			end
		end
	end

	// Stimulus and end of run
	initial begin
		logic [4:0] op;
		logic signed [DATA_W-1:0] a;
		logic signed [DATA_W-1:0] b;
		logic [1:0] lk;
		logic [1:0] rk;

		// directed corners
		add_beat(OP_ADD, I64_MAX, 1, KIND_INT, KIND_INT, 1'b1);
		add_beat(OP_SUB, I64_MIN, 1, KIND_INT, KIND_INT, 1'b0);
		add_beat(OP_MUL, I64_MIN, MINUS_ONE, KIND_INT, KIND_INT, 1'b0);
		add_beat(OP_MUL, 64'sd3037000499, -64'sd3037000499, KIND_INT, KIND_INT, 1'b0);
		add_beat(OP_DIV, I64_MIN, MINUS_ONE, KIND_INT, KIND_INT, 1'b0);
		add_beat(OP_DIV, -64'sd7, 64'sd2, KIND_INT, KIND_INT, 1'b0);
		add_beat(OP_MOD, -64'sd7, 0, KIND_INT, KIND_INT, 1'b0);
		add_beat(OP_MOD, -64'sd7, 64'sd2, KIND_INT, KIND_INT, 1'b0);
		add_beat(OP_POW, 0, 0, KIND_INT, KIND_INT, 1'b0);
		add_beat(OP_POW, 64'sd3, MINUS_ONE, KIND_INT, KIND_INT, 1'b0);
		add_beat(OP_POW, 64'sd2, DATA_W'(POW_LIMIT + 1), KIND_INT, KIND_INT, 1'b0);
		add_beat(OP_POW, 64'sd10, DATA_W'(POW_LIMIT), KIND_INT, KIND_INT, 1'b0);
		add_beat(OP_POW, -64'sd8, DATA_W'(POW_LIMIT), KIND_INT, KIND_INT, 1'b0);
		add_beat(OP_EQ, I64_MIN, I64_MIN, KIND_INT, KIND_INT, 1'b0);
		add_beat(OP_NE, I64_MAX, I64_MIN, KIND_INT, KIND_INT, 1'b0);
		add_beat(OP_LT, I64_MIN, I64_MAX, KIND_INT, KIND_INT, 1'b0);
		add_beat(OP_GT, MINUS_ONE, 0, KIND_INT, KIND_INT, 1'b0);
		add_beat(OP_LE, I64_MAX, I64_MAX, KIND_INT, KIND_INT, 1'b0);
		add_beat(OP_GE, I64_MIN, MINUS_ONE, KIND_INT, KIND_INT, 1'b0);
		add_beat(OP_LAND, 1, 64'sd5, KIND_BOOL, KIND_BOOL, 1'b0);
		add_beat(OP_LOR, 0, 0, KIND_INT, KIND_BOOL, 1'b0);
		add_beat(OP_BXOR, I64_MAX, MINUS_ONE, KIND_SPARE, KIND_INT, 1'b0);
		add_beat(OP_SHL, I64_MAX, DATA_W'(DATA_W - 1), KIND_INT, KIND_INT, 1'b0);
		add_beat(OP_SHR, I64_MIN, DATA_W'(DATA_W - 1), KIND_INT, KIND_INT, 1'b0);
		add_beat(OP_SHR, 64'sd1, MINUS_ONE, KIND_INT, KIND_INT, 1'b0);
		add_beat(OP_SHL, 64'sd1, DATA_W'(DATA_W), KIND_INT, KIND_INT, 1'b0);
		add_beat(5'(OP_CODE_TOP), 64'sd4, 64'sd4, KIND_INT, KIND_INT, 1'b0);
		add_beat(OP_ADD, 1, 64'sd2, KIND_BOOL, KIND_INT, 1'b0);
		add_beat(OP_MOD, 64'sd9, 64'sd4, KIND_INT, KIND_OTHER, 1'b0);
		n_directed = n_total;

		// random operations, well-formed most of the time
		for (int i = 0; i < RANDOM_BEATS; i++) begin
			if ($urandom_range(19, 0) == 0)
				op = 5'($urandom_range(OP_CODE_TOP, OP_SHR + 1));
			else
				op = 5'($urandom_range(OP_SHR, OP_ADD));
			a = pick_operand();
			b = pick_operand();
			case (op)
				OP_POW: begin
					if ($urandom_range(3, 0) != 0)
						a = $signed(64'($urandom_range(24, 0))) - 12;
					if ($urandom_range(5, 0) != 0)
						b = DATA_W'($urandom_range(POW_LIMIT + 2, 0));
				end
				OP_SHL, OP_SHR: begin
					if ($urandom_range(7, 0) != 0)
						b = DATA_W'($urandom_range(DATA_W + 6, 0));
				end
				OP_DIV, OP_MOD: begin
					if ($urandom_range(9, 0) == 0)
						b = 0;
					else if ($urandom_range(19, 0) == 0) begin
						a = I64_MIN;
						b = MINUS_ONE;
					end
				end
				OP_LAND, OP_LOR: begin
					if ($urandom_range(3, 0) != 0) begin
						a = DATA_W'($urandom_range(1, 0));
						b = DATA_W'($urandom_range(1, 0));
					end
				end
				default: ;
			endcase
			// operand kinds: mostly the ones the operation wants
			if ((op == OP_LAND || op == OP_LOR) && $urandom_range(4, 0) != 0) begin
				lk = KIND_BOOL;
				rk = KIND_BOOL;
			end else if (op != OP_LAND && op != OP_LOR && $urandom_range(6, 0) != 0) begin
				lk = KIND_INT;
				rk = KIND_INT;
			end else begin
				lk = 2'($urandom_range(KIND_SPARE, KIND_INT));
				rk = 2'($urandom_range(KIND_SPARE, KIND_INT));
			end
			add_beat(op, a, b, lk, rk, (i == 0) || ($urandom_range(59, 0) == 0));
			// one stretch back to back
			if (i >= 200 && i < 260)
				alu_pending[$].gap = 0;
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		do
			@(posedge clk);
		while (n_acc != n_total || n_res != n_acc);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (alu_expected.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", alu_expected.size()));
		$display("Ran %0d directed and %0d random ALU operations, %0d results checked",
			n_directed, n_total - n_directed, n_res);
		$display("Outcomes: %0d valid, %0d deferred, %0d errors; %0d mismatches",
			n_valid, n_defer, n_fault, n_err);
		if (n_err == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// Watchdog
	initial begin
		#10_000_000;
		$display("Timeout: run did not complete");
		$display("Simulation FAILED");
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/cia_pkg.sv
hw/rtl/cia_ctrl.sv
hw/rtl/cia_dpath.sv
hw/rtl/checked_int64_alu.sv
tb/checked_int64_alu_tb.sv
